>>> sv/assert_macros.svh
// assertion helpers used by the checker
// both sample on aclk and stay quiet while aresetn is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define CHK_IMPLY(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define CHK_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

>>> sv/srarq_pkg.sv
package srarq_pkg;

    // stream payload widths
    localparam int SEQ_W     = 16;
    localparam int CMD_W     = 2;
    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 24;

    // configuration port
    localparam int CFG_DATA_W = 32;
    localparam int CFG_ADDR_W = 4;

    // register reset values
    localparam logic [4:0]  WINDOW_SLOTS_RST  = 5'd4;
    localparam logic [15:0] FRAME_COUNT_RST   = 16'd0;
    localparam logic [15:0] TIMEOUT_TICKS_RST = 16'd100;
    localparam logic        FINAL_BUFFER_RST  = 1'b0;

    typedef enum logic [CMD_W-1:0] {
        CMD_TICK    = 2'd0,
        CMD_ACK     = 2'd1,
        CMD_RESTART = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        REG_WINDOW_SLOTS  = 2'd0,
        REG_FRAME_COUNT   = 2'd1,
        REG_TIMEOUT_TICKS = 2'd2,
        REG_FINAL_BUFFER  = 2'd3
    } reg_idx_t;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_SLIDE  = 4'b0010,
        ST_SCAN   = 4'b0100,
        ST_STATUS = 4'b1000
    } state_t;

endpackage

>>> sv/srarq_sub.sv
module srarq_sub #(
    parameter int DW = 16
) (
    input  logic [DW-1:0] op_a,
    input  logic [DW-1:0] op_b,
    output logic [DW-1:0] diff,
    output logic          borrow
);

    // shared subtractor, borrow set when op_a < op_b
    assign {borrow, diff} = {1'b0, op_a} - {1'b0, op_b};

endmodule

>>> sv/selective_repeat_arq_sender.sv
// channel   | dir | handshake                 | payload
// s_ (cmd)  | in  | s_tvalid / s_tready       | tuser command, tdata ack fields
// m_ (send) | out | m_tvalid / m_tready       | tuser send_valid, tdata frame, tlast
// cfg (apb) | in  | psel / penable / pready   | paddr 4*index, pwdata / prdata
//
// ack, restart and unused commands are handled in the idle state as they are accepted
// a tick goes through slide, scan and status: one slide step per leading acked slot,
// one scan step per window slot in use, then the status item; acks and scans share one subtractor
// a full output register slows the scan and the status item, nothing else
// reset (aresetn low, synchronous) empties the window, zeroes the tick clock and
// loads the register defaults; send times are never cleared and are only read for sent slots
module selective_repeat_arq_sender #(
    parameter int WINDOW_MAX = 16,
    parameter int TIME_BITS  = 16
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // input items
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [srarq_pkg::S_TDATA_W-1:0]     s_tdata,   // ack_num, ack_negative, ack_corrupt
    input  logic [srarq_pkg::CMD_W-1:0]         s_tuser,   // command
    // result items
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [srarq_pkg::M_TDATA_W-1:0]     m_tdata,   // send_seqnum, send_end_flag, buffer_done
    output logic [0:0]                          m_tuser,   // send_valid
    output logic                                m_tlast,   // last_item
    // configuration
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [srarq_pkg::CFG_ADDR_W-1:0]    paddr,
    input  logic [srarq_pkg::CFG_DATA_W-1:0]    pwdata,
    output logic [srarq_pkg::CFG_DATA_W-1:0]    prdata,
    output logic                                pready
);

    localparam int IW  = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int WCW = $clog2(WINDOW_MAX + 1);
    localparam int SW  = (WCW > 5) ? WCW : 5;
    localparam int DW  = (TIME_BITS > 16) ? TIME_BITS : 16;
    localparam int SQ  = srarq_pkg::SEQ_W;

    typedef logic [WINDOW_MAX-1:0][TIME_BITS-1:0] time_arr_t;

    // configuration registers
    logic [4:0]    window_slots_reg;
    logic [SQ-1:0] frame_count_reg;
    logic [15:0]   timeout_ticks_reg;
    logic          final_buffer_reg;

    // window state
    srarq_pkg::state_t     state_reg, state_next;
    logic [SQ-1:0]         base_reg, base_next;
    logic [TIME_BITS-1:0]  clock_reg, clock_next;
    logic [WINDOW_MAX-1:0] acked_reg, acked_next;
    logic [WINDOW_MAX-1:0] sent_reg, sent_next;
    time_arr_t             time_reg, time_next;
    logic [SW-1:0]         scan_cnt_reg, scan_cnt_next;

    // output register
    logic                            m_tvalid_reg, m_tvalid_next;
    logic [srarq_pkg::M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;
    logic                            m_tuser_reg, m_tuser_next;
    logic                            m_tlast_reg, m_tlast_next;

    // decoded input item
    srarq_pkg::cmd_t in_cmd;
    logic [SQ-1:0]   in_ack_seq;
    logic            in_ack_neg;
    logic            in_ack_corrupt;
    logic            in_accept;

    // shared subtractor
    logic [DW-1:0] sub_a, sub_b, sub_diff;
    logic          sub_borrow;

    logic [SW-1:0]         w_used;
    logic [SW-1:0]         ws_ext;
    logic [WINDOW_MAX-1:0] win_mask, keep_mask;
    logic [IW-1:0]         ack_off, scan_idx;
    logic                  ack_hit;
    logic [TIME_BITS-1:0]  age;
    logic                  age_over;
    logic [SQ:0]           seq_wide;
    logic                  in_range, end_flag, buffer_done, slot_due;
    logic                  scan_end, out_free, cfg_write;

    assign in_cmd         = srarq_pkg::cmd_t'(s_tuser);
    assign in_ack_seq     = s_tdata[SQ-1:0];
    assign in_ack_neg     = s_tdata[SQ];
    assign in_ack_corrupt = s_tdata[SQ+1];
    assign s_tready       = (state_reg == srarq_pkg::ST_IDLE);
    assign in_accept      = s_tvalid && s_tready;
    assign out_free       = !m_tvalid_reg || m_tready;

    // window size in use, clamped to 1..WINDOW_MAX
    assign ws_ext = SW'(window_slots_reg);
    always_comb begin
        priority if (ws_ext == '0) begin
            w_used = SW'(1);
        end else if (ws_ext > SW'(WINDOW_MAX)) begin
            w_used = SW'(WINDOW_MAX);
        end else begin
            w_used = ws_ext;
        end
    end

    // slot masks for the one-step slide
    always_comb begin
        for (int j = 0; j < WINDOW_MAX; j++) begin
            win_mask[j]  = (SW'(j) < w_used);
            keep_mask[j] = (SW'(j + 1) < w_used);
        end
    end

    // subtractor operands: send age while scanning, ack offset otherwise
    assign scan_idx = scan_cnt_reg[IW-1:0];
    always_comb begin
        if (state_reg == srarq_pkg::ST_SCAN) begin
            sub_a = DW'(clock_reg);
            sub_b = DW'(time_reg[scan_idx]);
        end else begin
            sub_a = DW'(in_ack_seq);
            sub_b = DW'(base_reg);
        end
    end

    srarq_sub #(
        .DW (DW)
    ) u_sub (
        .op_a   (sub_a),
        .op_b   (sub_b),
        .diff   (sub_diff),
        .borrow (sub_borrow)
    );

    // ack must sit at or above the base and within the window
    assign ack_off  = sub_diff[IW-1:0];
    assign ack_hit  = !in_ack_corrupt && !sub_borrow && (sub_diff < DW'(w_used));

    // age wraps with the tick clock
    assign age      = sub_diff[TIME_BITS-1:0];
    assign age_over = (DW'(age) > DW'(timeout_ticks_reg));

    // frame number of the slot under scan, no wrap
    assign seq_wide    = {1'b0, base_reg} + (SQ+1)'(scan_cnt_reg);
    assign in_range    = (seq_wide < {1'b0, frame_count_reg});
    assign end_flag    = final_buffer_reg && ((seq_wide + 1'b1) == {1'b0, frame_count_reg});
    assign buffer_done = (base_reg >= frame_count_reg);
    assign scan_end    = (scan_cnt_reg == w_used);
    assign slot_due    = in_range && !acked_reg[scan_idx] && (!sent_reg[scan_idx] || age_over);

    // sequencer
    always_comb begin
        state_next    = state_reg;
        base_next     = base_reg;
        clock_next    = clock_reg;
        acked_next    = acked_reg;
        sent_next     = sent_reg;
        time_next     = time_reg;
        scan_cnt_next = scan_cnt_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        m_tlast_next  = m_tlast_reg;

        unique case (state_reg)
            srarq_pkg::ST_IDLE: begin
                if (in_accept) begin
                    unique case (in_cmd)
                        srarq_pkg::CMD_TICK: begin
                            clock_next = clock_reg + 1'b1;
                            state_next = srarq_pkg::ST_SLIDE;
                        end
                        srarq_pkg::CMD_ACK: begin
                            if (ack_hit) begin
                                // a nack forces a resend, the acked bit stays
                                if (!in_ack_neg) begin
                                    acked_next[ack_off] = 1'b1;
                                end else begin
                                    sent_next[ack_off] = 1'b0;
                                end
                            end
                        end
                        srarq_pkg::CMD_RESTART: begin
                            acked_next = '0;
                            sent_next  = '0;
                            base_next  = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            srarq_pkg::ST_SLIDE: begin
                // one slot per cycle past the leading acked slots
                if (acked_reg[0]) begin
                    acked_next = ((acked_reg >> 1) & keep_mask) | (acked_reg & ~win_mask);
                    sent_next  = ((sent_reg >> 1) & keep_mask) | (sent_reg & ~win_mask);
                    for (int j = 0; j < WINDOW_MAX - 1; j++) begin
                        if (keep_mask[j]) begin
                            time_next[j] = time_reg[j + 1];
                        end
                    end
                    base_next = base_reg + 1'b1;
                end else begin
                    scan_cnt_next = '0;
                    state_next    = srarq_pkg::ST_SCAN;
                end
            end
            srarq_pkg::ST_SCAN: begin
                if (scan_end) begin
                    state_next = srarq_pkg::ST_STATUS;
                end else if (slot_due) begin
                    if (out_free) begin
                        m_tvalid_next       = 1'b1;
                        m_tdata_next        = srarq_pkg::M_TDATA_W'(
                                              {buffer_done, end_flag, seq_wide[SQ-1:0]});
                        m_tuser_next        = 1'b1;
                        m_tlast_next        = 1'b0;
                        sent_next[scan_idx] = 1'b1;
                        time_next[scan_idx] = clock_reg;
                        scan_cnt_next       = scan_cnt_reg + 1'b1;
                    end
                end else begin
                    scan_cnt_next = scan_cnt_reg + 1'b1;
                end
            end
            srarq_pkg::ST_STATUS: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = srarq_pkg::M_TDATA_W'({buffer_done, 1'b0, SQ'(0)});
                    m_tuser_next  = 1'b0;
                    m_tlast_next  = 1'b1;
                    state_next    = srarq_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = srarq_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= srarq_pkg::ST_IDLE;
            base_reg     <= '0;
            clock_reg    <= '0;
            acked_reg    <= '0;
            sent_reg     <= '0;
            scan_cnt_reg <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            base_reg     <= base_next;
            clock_reg    <= clock_next;
            acked_reg    <= acked_next;
            sent_reg     <= sent_next;
            scan_cnt_reg <= scan_cnt_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // send times and output payload, no reset
    always_ff @(posedge aclk) begin
        time_reg    <= time_next;
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
        m_tlast_reg <= m_tlast_next;
    end

    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = m_tdata_reg;
    assign m_tuser[0] = m_tuser_reg;
    assign m_tlast    = m_tlast_reg;

    // configuration port, register i at byte address 4*i
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_slots_reg  <= srarq_pkg::WINDOW_SLOTS_RST;
            frame_count_reg   <= srarq_pkg::FRAME_COUNT_RST;
            timeout_ticks_reg <= srarq_pkg::TIMEOUT_TICKS_RST;
            final_buffer_reg  <= srarq_pkg::FINAL_BUFFER_RST;
        end else if (cfg_write) begin
            unique case (srarq_pkg::reg_idx_t'(paddr[3:2]))
                srarq_pkg::REG_WINDOW_SLOTS:  window_slots_reg  <= pwdata[4:0];
                srarq_pkg::REG_FRAME_COUNT:   frame_count_reg   <= pwdata[15:0];
                srarq_pkg::REG_TIMEOUT_TICKS: timeout_ticks_reg <= pwdata[15:0];
                srarq_pkg::REG_FINAL_BUFFER:  final_buffer_reg  <= pwdata[0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (srarq_pkg::reg_idx_t'(paddr[3:2]))
            srarq_pkg::REG_WINDOW_SLOTS:  prdata = srarq_pkg::CFG_DATA_W'(window_slots_reg);
            srarq_pkg::REG_FRAME_COUNT:   prdata = srarq_pkg::CFG_DATA_W'(frame_count_reg);
            srarq_pkg::REG_TIMEOUT_TICKS: prdata = srarq_pkg::CFG_DATA_W'(timeout_ticks_reg);
            srarq_pkg::REG_FINAL_BUFFER:  prdata = srarq_pkg::CFG_DATA_W'(final_buffer_reg);
            default:                      prdata = '0;
        endcase
    end

endmodule

>>> sv/srarq_checker.sv
`include "assert_macros.svh"

module srarq_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic [srarq_pkg::CMD_W-1:0]     s_tuser,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [srarq_pkg::M_TDATA_W-1:0] m_tdata,
    input logic [0:0]                      m_tuser,
    input logic                            m_tlast
);

    // a stalled result item keeps its payload
    `CHK_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast))

    // the status item carries no frame and no end flag
    `CHK_IMPLY(a_status_clean, m_tvalid && m_tlast, (m_tuser[0] == 1'b0) && (m_tdata[16:0] == 17'd0))

    // a send request never closes the tick
    `CHK_IMPLY(a_send_not_last, m_tvalid && m_tuser[0], !m_tlast)

    // an accepted tick occupies the engine in the next cycle
    `CHK_NEXT(a_tick_busy, s_tvalid && s_tready && (s_tuser == srarq_pkg::CMD_TICK), !s_tready)

endmodule

bind selective_repeat_arq_sender srarq_checker u_srarq_checker (.*);

>>> bench/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WIN_MAX      = 16;
    localparam int STUCK_LIMIT  = 2000;   // cycles with no handshake on any port
    localparam int DRAIN_CYCLES = 48;
    localparam int LONG_HOLD    = 300;
    localparam logic [srarq_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;

    // one command item as it travels on the input channel
    typedef struct packed {
        logic [srarq_pkg::CMD_W-1:0] command;
        logic [15:0]                 ack_num;
        logic                        ack_negative;
        logic                        ack_corrupt;
    } arq_cmd_t;

    // one send request or tick status item
    typedef struct packed {
        logic        send_valid;
        logic [15:0] send_seqnum;
        logic        send_end_flag;
        logic        buffer_done;
        logic        last_item;
    } send_req_t;

    logic                             aclk     = 1'b0;
    logic                             aresetn  = 1'b0;
    logic                             s_tvalid = 1'b0;
    logic                             s_tready;
    logic [srarq_pkg::S_TDATA_W-1:0]  s_tdata  = '0;   // ack_num, ack_negative, ack_corrupt
    logic [srarq_pkg::CMD_W-1:0]      s_tuser  = '0;   // command
    logic                             m_tvalid;
    logic                             m_tready = 1'b0;
    logic [srarq_pkg::M_TDATA_W-1:0]  m_tdata;         // send_seqnum, send_end_flag, buffer_done
    logic [0:0]                       m_tuser;         // send_valid
    logic                             m_tlast;         // last_item
    logic                             psel     = 1'b0;
    logic                             penable  = 1'b0;
    logic                             pwrite   = 1'b0;
    logic [srarq_pkg::CFG_ADDR_W-1:0] paddr    = '0;
    logic [srarq_pkg::CFG_DATA_W-1:0] pwdata   = '0;
    logic [srarq_pkg::CFG_DATA_W-1:0] prdata;
    logic                             pready;

    selective_repeat_arq_sender i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // register mirror, follows every write on the config port
    logic [4:0]  cfg_slots   = srarq_pkg::WINDOW_SLOTS_RST;
    logic [15:0] cfg_frames  = srarq_pkg::FRAME_COUNT_RST;
    logic [15:0] cfg_timeout = srarq_pkg::TIMEOUT_TICKS_RST;
    logic        cfg_final   = srarq_pkg::FINAL_BUFFER_RST;

    // window state as the block should hold it
    logic [15:0] win_base = '0;
    logic [15:0] tick_now = '0;
    bit          slot_ack   [WIN_MAX] = '{default: 1'b0};
    bit          slot_tx    [WIN_MAX] = '{default: 1'b0};
    logic [15:0] slot_tx_at [WIN_MAX] = '{default: '0};

    arq_cmd_t  pending_cmds [$];   // items still to be offered
    send_req_t owed_sends   [$];   // result items the block still owes

    arq_cmd_t cur_cmd      = '0;
    bit       offering     = 1'b0;
    bit       cmd_taken    = 1'b0;
    bit       res_taken    = 1'b0;
    bit       send_lazy    = 1'b0;
    bit       rcv_lazy     = 1'b0;
    bit       want_long_hold = 1'b0;
    int       cmd_gap      = 0;
    int       rdy_wait     = 0;
    int       hold_left    = 0;
    int       stuck_cycles = 0;
    int       fail_count   = 0;
    int       results_seen = 0;

    // slots in use: zero acts as one, anything past the maximum as the maximum
    function automatic int active_slots();
        if (cfg_slots == 0)
            return 1;
        if (cfg_slots > WIN_MAX)
            return WIN_MAX;
        return int'(cfg_slots);
    endfunction

    function automatic void flag_error(string msg);
        fail_count++;
        if (fail_count <= 10)
            $display("%s", msg);
    endfunction

    // work out what one accepted item does to the window and what it yields
    task automatic window_step(input arq_cmd_t c);
        int          w, run, off, seq, i;
        logic        done;
        logic [15:0] age;
        send_req_t   req;
        w = active_slots();
        case (c.command)
            srarq_pkg::CMD_RESTART: begin
                for (i = 0; i < WIN_MAX; i++) begin
                    slot_ack[i]   = 1'b0;
                    slot_tx[i]    = 1'b0;
                    slot_tx_at[i] = '0;
                end
                win_base = '0;
            end
            srarq_pkg::CMD_ACK: begin
                off = int'(c.ack_num) - int'(win_base);
                if (!c.ack_corrupt && off >= 0 && off < w) begin
                    // a negative ack only forces a resend, the acked bit stays
                    if (c.ack_negative)
                        slot_tx[off] = 1'b0;
                    else
                        slot_ack[off] = 1'b1;
                end
            end
            srarq_pkg::CMD_TICK: begin
                tick_now = tick_now + 16'd1;
                run = 0;
                while (run < w && slot_ack[run])
                    run++;
                if (run > 0) begin
                    for (i = 0; i < w; i++) begin
                        if (i + run < w) begin
                            slot_ack[i]   = slot_ack[i + run];
                            slot_tx[i]    = slot_tx[i + run];
                            slot_tx_at[i] = slot_tx_at[i + run];
                        end else begin
                            slot_ack[i]   = 1'b0;
                            slot_tx[i]    = 1'b0;
                            slot_tx_at[i] = '0;
                        end
                    end
                    win_base = win_base + 16'(run);
                end
                done = (win_base >= cfg_frames);
                for (i = 0; i < w; i++) begin
                    // sequence number without wrap, frames past the buffer stay quiet
                    seq = int'(win_base) + i;
                    age = tick_now - slot_tx_at[i];
                    if (seq < int'(cfg_frames) && !slot_ack[i]
                            && (!slot_tx[i] || age > cfg_timeout)) begin
                        slot_tx[i]        = 1'b1;
                        slot_tx_at[i]     = tick_now;
                        req.send_valid    = 1'b1;
                        req.send_seqnum   = 16'(seq);
                        req.send_end_flag = cfg_final && (seq + 1 == int'(cfg_frames));
                        req.buffer_done   = done;
                        req.last_item     = 1'b0;
                        owed_sends.push_back(req);
                    end
                end
                req = '0;
                req.buffer_done = done;
                req.last_item   = 1'b1;
                owed_sends.push_back(req);
            end
            default: ;   // unused command is ignored
        endcase
    endtask

    // input side: prediction on every accepted item
    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready) begin
            cmd_taken = 1'b1;
            window_step(cur_cmd);
        end
    end

    // input driver, one item at a time from the pending queue
    always @(negedge aclk) begin
        if (cmd_taken) begin
            cmd_taken = 1'b0;
            offering  = 1'b0;
            cmd_gap   = send_lazy ? $urandom_range(0, 6) : 0;
        end
        if (aresetn && !offering) begin
            if (cmd_gap > 0) begin
                cmd_gap--;
            end else if (pending_cmds.size() != 0) begin
                cur_cmd  = pending_cmds.pop_front();
                offering = 1'b1;
            end
        end
        s_tvalid <= offering;
        s_tdata  <= {6'b0, cur_cmd.ack_corrupt, cur_cmd.ack_negative, cur_cmd.ack_num};
        s_tuser  <= cur_cmd.command;
    end

    // result side: compare each item with the oldest one owed
    always @(posedge aclk) begin
        send_req_t want;
        send_req_t got;
        if (aresetn && m_tvalid && m_tready) begin
            res_taken = 1'b1;
            results_seen++;
            got.send_valid    = m_tuser[0];
            got.send_seqnum   = m_tdata[15:0];
            got.send_end_flag = m_tdata[16];
            got.buffer_done   = m_tdata[17];
            got.last_item     = m_tlast;
            if (owed_sends.size() == 0) begin
                flag_error($sformatf("item %0d: unexpected result valid %b seq %0d last %b",
                                     results_seen, got.send_valid, got.send_seqnum,
                                     got.last_item));
            end else begin
                want = owed_sends.pop_front();
                if (got.send_valid !== want.send_valid
                        || got.send_seqnum !== want.send_seqnum
                        || got.send_end_flag !== want.send_end_flag
                        || got.buffer_done !== want.buffer_done
                        || got.last_item !== want.last_item)
                    flag_error($sformatf({"item %0d: expected valid %b seq %0d end %b ",
                                          "done %b last %b, got valid %b seq %0d end %b ",
                                          "done %b last %b"}, results_seen,
                                         want.send_valid, want.send_seqnum,
                                         want.send_end_flag, want.buffer_done,
                                         want.last_item, got.send_valid, got.send_seqnum,
                                         got.send_end_flag, got.buffer_done, got.last_item));
            end
        end
    end

    // receiver readiness: random wait per item, plus one long hold on request
    always @(negedge aclk) begin
        if (res_taken) begin
            res_taken = 1'b0;
            rdy_wait  = rcv_lazy ? $urandom_range(0, 6) : 0;
        end
        if (want_long_hold) begin
            want_long_hold = 1'b0;
            hold_left      = LONG_HOLD;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else if (rdy_wait > 0) begin
            rdy_wait--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // watchdog on cycles in which nothing moves
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
            stuck_cycles <= 0;
        else
            stuck_cycles <= stuck_cycles + 1;
    end

    initial begin
        wait (stuck_cycles >= STUCK_LIMIT);
        $display("Verification failed");
        $finish;
    end

    function automatic void queue_cmd(input logic [srarq_pkg::CMD_W-1:0] op,
                                      input logic [15:0] seq = '0,
                                      input logic neg = 1'b0,
                                      input logic bad = 1'b0);
        arq_cmd_t c;
        c.command      = op;
        c.ack_num      = seq;
        c.ack_negative = neg;
        c.ack_corrupt  = bad;
        pending_cmds.push_back(c);
    endfunction

    // mostly ticks and acks that land in the current window, some noise
    function automatic void queue_random_cmd();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 30)
            queue_cmd(srarq_pkg::CMD_TICK);
        else if (roll < 78)
            queue_cmd(srarq_pkg::CMD_ACK,
                      win_base + 16'($urandom_range(0, active_slots() - 1)),
                      $urandom_range(0, 4) == 0);
        else if (roll < 86)
            queue_cmd(srarq_pkg::CMD_ACK, 16'($urandom), $urandom_range(0, 1),
                      $urandom_range(0, 1));
        else if (roll < 92)
            queue_cmd(srarq_pkg::CMD_ACK,
                      win_base + 16'($urandom_range(0, active_slots() - 1)),
                      $urandom_range(0, 1), 1'b1);
        else if (roll < 96)
            queue_cmd(srarq_pkg::CMD_RESTART, 16'($urandom), $urandom_range(0, 1),
                      $urandom_range(0, 1));
        else
            queue_cmd(CMD_UNUSED, 16'($urandom), $urandom_range(0, 1), $urandom_range(0, 1));
    endfunction

    // setup then access write on the config port, mirror updated at the write edge
    task automatic write_reg(input srarq_pkg::reg_idx_t idx,
                             input logic [srarq_pkg::CFG_DATA_W-1:0] value);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready)
            @(posedge aclk);
        case (idx)
            srarq_pkg::REG_WINDOW_SLOTS:  cfg_slots   = value[4:0];
            srarq_pkg::REG_FRAME_COUNT:   cfg_frames  = value[15:0];
            srarq_pkg::REG_TIMEOUT_TICKS: cfg_timeout = value[15:0];
            srarq_pkg::REG_FINAL_BUFFER:  cfg_final   = value[0];
            default: ;
        endcase
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic apply_config(input logic [4:0] slots, input logic [15:0] frames,
                                input logic [15:0] timeout, input logic fin);
        write_reg(srarq_pkg::REG_WINDOW_SLOTS, 32'(slots));
        write_reg(srarq_pkg::REG_FRAME_COUNT, 32'(frames));
        write_reg(srarq_pkg::REG_TIMEOUT_TICKS, 32'(timeout));
        write_reg(srarq_pkg::REG_FINAL_BUFFER, 32'(fin));
    endtask

    // waits until every queued item is taken and every owed item is in, then lets the block go quiet
    task automatic settle();
        @(posedge aclk);
        while (pending_cmds.size() != 0 || offering || owed_sends.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    initial begin
        int          ph, n, batch;
        logic [4:0]  slots_pick;
        logic [15:0] frames_pick, timeout_pick;

        repeat (7) @(negedge aclk);
        aresetn <= 1'b1;

        // directed: six frames, window of four, short timeout, end flag on
        apply_config(5'd4, 16'd6, 16'd3, 1'b1);
        queue_cmd(srarq_pkg::CMD_TICK);                     // first sends 0 to 3
        queue_cmd(srarq_pkg::CMD_ACK, 16'd1);
        queue_cmd(srarq_pkg::CMD_ACK, 16'd0, 1'b1);         // negative, slot 0 goes out again
        queue_cmd(srarq_pkg::CMD_ACK, 16'd2, 1'b0, 1'b1);   // bad checksum, ignored
        queue_cmd(srarq_pkg::CMD_ACK, 16'd9);               // outside the window
        queue_cmd(CMD_UNUSED, 16'hFFFF, 1'b1, 1'b1);        // unused command
        queue_cmd(srarq_pkg::CMD_TICK);
        queue_cmd(srarq_pkg::CMD_ACK, 16'd0);
        queue_cmd(srarq_pkg::CMD_TICK);                     // slides two, frame 5 has end flag
        queue_cmd(srarq_pkg::CMD_TICK);
        queue_cmd(srarq_pkg::CMD_TICK);                     // timeout passes for 2 and 3
        queue_cmd(srarq_pkg::CMD_ACK, 16'd2);
        queue_cmd(srarq_pkg::CMD_ACK, 16'd3);
        queue_cmd(srarq_pkg::CMD_ACK, 16'd3, 1'b1);         // negative after positive, stays acked
        queue_cmd(srarq_pkg::CMD_ACK, 16'd4);
        queue_cmd(srarq_pkg::CMD_ACK, 16'd5);
        queue_cmd(srarq_pkg::CMD_TICK);                     // buffer done
        queue_cmd(srarq_pkg::CMD_ACK, 16'd7);               // frame past the buffer, still taken
        queue_cmd(srarq_pkg::CMD_TICK);
        queue_cmd(srarq_pkg::CMD_ACK, 16'd6);
        queue_cmd(srarq_pkg::CMD_TICK);
        queue_cmd(srarq_pkg::CMD_RESTART);
        queue_cmd(srarq_pkg::CMD_TICK);
        settle();

        // directed: window size zero, largest buffer, zero timeout, then oversize window
        apply_config(5'd0, 16'hFFFF, 16'd0, 1'b0);
        queue_cmd(srarq_pkg::CMD_RESTART);
        queue_cmd(srarq_pkg::CMD_TICK);
        queue_cmd(srarq_pkg::CMD_TICK);
        settle();
        write_reg(srarq_pkg::REG_WINDOW_SLOTS, 32'd31);
        queue_cmd(srarq_pkg::CMD_TICK);
        queue_cmd(srarq_pkg::CMD_TICK);
        settle();

        // long receiver hold while the sender keeps pushing ticks
        send_lazy = 1'b0;
        rcv_lazy  = 1'b0;
        apply_config(5'd16, 16'd40, 16'd2, 1'b1);
        queue_cmd(srarq_pkg::CMD_RESTART);
        want_long_hold = 1'b1;
        repeat (12) queue_cmd(srarq_pkg::CMD_TICK);
        settle();

        // random phases with varied settings and idling
        for (ph = 0; ph < 6; ph++) begin
            send_lazy = $urandom_range(0, 3) != 0;
            rcv_lazy  = $urandom_range(0, 3) != 0;
            case ($urandom_range(0, 5))
                0:       slots_pick = 5'd0;
                1:       slots_pick = 5'd16;
                2:       slots_pick = 5'd31;
                3:       slots_pick = 5'd1;
                default: slots_pick = 5'($urandom_range(2, 15));
            endcase
            case ($urandom_range(0, 4))
                0:       frames_pick = 16'd0;
                1:       frames_pick = 16'hFFFF;
                default: frames_pick = 16'($urandom_range(1, 40));
            endcase
            case ($urandom_range(0, 5))
                0:       timeout_pick = 16'd0;
                1:       timeout_pick = 16'd1;
                2:       timeout_pick = 16'hFFFF;
                default: timeout_pick = 16'($urandom_range(2, 6));
            endcase
            apply_config(slots_pick, frames_pick, timeout_pick, 1'($urandom_range(0, 1)));
            // without a restart, slots that come back into use keep old bits
            if ($urandom_range(0, 2) != 0)
                queue_cmd(srarq_pkg::CMD_RESTART);
            n = 0;
            while (n < 18) begin
                batch = $urandom_range(1, 5);
                repeat (batch) queue_random_cmd();
                n += batch;
                // let the window catch up so acks aim at its current base
                while (pending_cmds.size() != 0)
                    @(posedge aclk);
            end
            settle();
        end

        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

>>> sim.f
+incdir+sv
sv/srarq_pkg.sv
sv/srarq_sub.sv
sv/selective_repeat_arq_sender.sv
sv/srarq_checker.sv
bench/tb.sv
